FILE: rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
// Holds the parser phase encoding, event codes and the hex digit decode.
// No dependencies.
package hcbd_pkg;

   typedef enum logic [3:0] {
      PH_SIZE    = 4'd0,
      PH_SIZE_CR = 4'd1,
      PH_EXT     = 4'd2,
      PH_EXT_CR  = 4'd3,
      PH_DATA    = 4'd4,
      PH_DATA_CR = 4'd5,
      PH_DATA_LF = 4'd6,
      PH_LAST_CR = 4'd7,
      PH_LAST_LF = 4'd8,
      PH_DONE    = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      EV_CONSUMED  = 3'd0,
      EV_DATA      = 3'd1,
      EV_COMPLETE  = 3'd2,
      EV_INVALID   = 3'd3,
      EV_TOO_LARGE = 3'd4
   } event_kind_type;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // bit 4 set when the byte is a hex digit, bits 3:0 give its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      begin
         case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
            default:       r = 5'd0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: rtl/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked transfer body decoder, one byte per request.
// Depends on hcbd_pkg for phase encoding, event codes and hex decode.
//
// Usage:
//   Request channel (req_*): one raw body byte per request in req_tdata; req_tuser
//   set on the first byte of a message clears the parser before that byte is
//   parsed. Response channel (rsp_*): exactly one response per request, holding
//   the event kind (consumed, data byte, complete, invalid, too large) and the
//   payload byte for data events (zero otherwise).
//   csr_wr_en / csr_wr_data load the body size limit; write only while idle.
// Timing:
//   Each request is parsed in the cycle it is accepted and its response is
//   registered, so the response appears in the cycle after acceptance. One
//   request per cycle is sustained unless the receiver stalls; the parser
//   state update is one phase machine step plus a 32-bit increment and compare.
// Reset:
//   Synchronous reset returns the parser to the size line, clears counters,
//   empties the response register and loads the limit with 1 MiB.
// Backpressure:
//   The response register refills in the cycle it is taken, so a request is
//   accepted whenever the register is empty or being drained. While the
//   receiver stalls with a response pending, req_tready stays low.
module http_chunked_body_decoder_core #(
   parameter int SIZE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hcbd_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] in_byte
   input  logic                           req_tuser,  // [0] start_message
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hcbd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [2:0] event_kind,
                                                      // [10:3] data_byte, [15:11] zero
   // limit register
   input  logic                           csr_wr_en,
   input  logic [31:0]                    csr_wr_data  // max_body_bytes
);
   import hcbd_pkg::*;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   chunk_ff, chunk_in;
   logic                   seen_ff, seen_in;
   logic [31:0]            total_ff, total_in;
   logic                   over_ff, over_in;
   logic [31:0]            max_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // working copy of state after an optional message restart
   phase_type              cur_phase;
   logic [SIZE_BITS-1:0]   cur_chunk;
   logic                   cur_seen;
   logic [31:0]            cur_total;
   logic                   cur_over;

   logic                   accept;
   logic [7:0]             c;
   logic [4:0]             hex;
   logic                   is_cr, is_lf, is_semi;
   logic                   size_full;
   logic [SIZE_BITS-1:0]   chunk_dec;
   phase_type              line_end_phase;
   event_kind_type         ev;
   logic [7:0]             dat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign c       = req_tdata;
   assign hex     = hex_digit(c);
   assign is_cr   = (c == CHAR_CR);
   assign is_lf   = (c == CHAR_LF);
   assign is_semi = (c == CHAR_SEMI);

   // start of message drops the parser back to the size line
   always_comb begin
      if (req_tuser) begin
         cur_phase = PH_SIZE;
         cur_chunk = '0;
         cur_seen  = 1'b0;
         cur_total = '0;
         cur_over  = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_chunk = chunk_ff;
         cur_seen  = seen_ff;
         cur_total = total_ff;
         cur_over  = over_ff;
      end
   end

   // another digit would shift bits out of the top of the size
   assign size_full = (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0);
   assign chunk_dec = cur_chunk - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   // where a completed size line leads
   always_comb begin
      if (!cur_seen) begin
         line_end_phase = PH_DONE;
      end else if (cur_chunk == '0) begin
         line_end_phase = PH_LAST_CR;
      end else begin
         line_end_phase = PH_DATA;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (cur_phase)
            PH_SIZE: begin
               if (hex[4]) begin
                  phase_in = size_full ? PH_DONE : PH_SIZE;
               end else if (is_semi) begin
                  phase_in = cur_seen ? PH_EXT : PH_DONE;
               end else if (is_cr) begin
                  phase_in = PH_SIZE_CR;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_SIZE_CR: phase_in = is_lf ? line_end_phase : PH_DONE;
            PH_EXT:     phase_in = is_cr ? PH_EXT_CR : PH_EXT;
            PH_EXT_CR: begin
               if (is_lf) begin
                  phase_in = line_end_phase;
               end else if (is_cr) begin
                  phase_in = PH_EXT_CR;
               end else begin
                  phase_in = PH_EXT;
               end
            end
            PH_DATA:    phase_in = (chunk_dec == '0) ? PH_DATA_CR : PH_DATA;
            PH_DATA_CR: phase_in = is_cr ? PH_DATA_LF : PH_DONE;
            PH_DATA_LF: phase_in = is_lf ? PH_SIZE : PH_DONE;
            PH_LAST_CR: phase_in = is_cr ? PH_LAST_LF : PH_DONE;
            PH_LAST_LF: phase_in = PH_DONE;
            default:    phase_in = PH_DONE;
         endcase
      end
   end

   // event, payload and counters
   always_comb begin
      ev       = EV_CONSUMED;
      dat      = 8'd0;
      chunk_in = chunk_ff;
      seen_in  = seen_ff;
      total_in = total_ff;
      over_in  = over_ff;
      if (accept) begin
         chunk_in = cur_chunk;
         seen_in  = cur_seen;
         total_in = cur_total;
         over_in  = cur_over;
         unique case (cur_phase)
            PH_SIZE: begin
               if (hex[4]) begin
                  if (size_full) begin
                     ev = EV_INVALID;
                  end else begin
                     chunk_in = {cur_chunk[SIZE_BITS-5:0], hex[3:0]};
                     seen_in  = 1'b1;
                  end
               end else if (is_semi) begin
                  if (!cur_seen) begin
                     ev = EV_INVALID;
                  end
               end else if (!is_cr) begin
                  ev = EV_INVALID;
               end
            end
            PH_SIZE_CR: begin
               if (!is_lf || !cur_seen) begin
                  ev = EV_INVALID;
               end
            end
            PH_EXT: ev = EV_CONSUMED;
            PH_EXT_CR: begin
               if (is_lf && !cur_seen) begin
                  ev = EV_INVALID;
               end
            end
            PH_DATA: begin
               ev       = EV_DATA;
               dat      = c;
               chunk_in = chunk_dec;
               if (cur_total >= max_ff) begin
                  over_in = 1'b1;
               end
               if (cur_total != 32'hFFFF_FFFF) begin
                  total_in = cur_total + 32'd1;
               end
            end
            PH_DATA_CR: begin
               if (!is_cr) begin
                  ev = EV_INVALID;
               end
            end
            PH_DATA_LF: begin
               if (is_lf) begin
                  chunk_in = '0;
                  seen_in  = 1'b0;
               end else begin
                  ev = EV_INVALID;
               end
            end
            PH_LAST_CR: begin
               if (!is_cr) begin
                  ev = EV_INVALID;
               end
            end
            PH_LAST_LF: begin
               if (is_lf) begin
                  ev = cur_over ? EV_TOO_LARGE : EV_COMPLETE;
               end else begin
                  ev = EV_INVALID;
               end
            end
            default: ev = EV_CONSUMED;
         endcase
      end
   end

   // response register: load on accept, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, dat, ev};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         chunk_ff     <= '0;
         seen_ff      <= 1'b0;
         total_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_BODY_RESET;
      end else begin
         phase_ff     <= phase_in;
         chunk_ff     <= chunk_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for http_chunked_body_decoder_core.
// Drives raw chunked-body bytes as requests and compares every response against
// an in-bench parser model. Depends on hcbd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
   import hcbd_pkg::*;

   localparam int SIZE_BITS   = 32;
   localparam int LIMIT_CYCLES = 300000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      event_kind_type kind;
      logic [7:0]     payload;
   } body_event_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // block ports; every input starts at a known value
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [7:0] in_byte
   logic                  req_tuser   = 1'b0; // [0] start_message
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [2:0] event_kind, [10:3] data_byte
   logic                  csr_wr_en   = 1'b0;
   logic [31:0]           csr_wr_data = '0;   // max_body_bytes

   http_chunked_body_decoder_core #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // pacing knobs, in percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // bookkeeping
   body_event_type expected_events[$];
   int             mismatch_count = 0;
   int             parsed_count   = 0;
   int             cycle_count    = 0;
   logic [7:0]     msg_bytes[$];

   // ---------------------------------------------------------------------
   // Parser model: its own copy of the phase machine and the limit register
   // ---------------------------------------------------------------------
   phase_type              body_phase = PH_SIZE;
   logic [SIZE_BITS-1:0]   chunk_left = '0;
   logic                   size_digit_seen = 1'b0;
   logic [31:0]            body_total = '0;
   logic                   body_over = 1'b0;
   logic [31:0]            body_limit = MAX_BODY_RESET;

   function automatic void clear_body_state();
      body_phase      = PH_SIZE;
      chunk_left      = '0;
      size_digit_seen = 1'b0;
      body_total      = '0;
      body_over       = 1'b0;
   endfunction

   function automatic event_kind_type reject_body();
      body_phase = PH_DONE;
      return EV_INVALID;
   endfunction

   // CR LF closing a size line: an empty size is invalid, zero means last chunk
   function automatic event_kind_type close_size_line();
      if (!size_digit_seen)
         return reject_body();
      body_phase = (chunk_left == '0) ? PH_LAST_CR : PH_DATA;
      return EV_CONSUMED;
   endfunction

   function automatic body_event_type decode_body_byte(input logic start, input logic [7:0] c);
      body_event_type ev;
      logic [3:0]     nib;
      logic [7:0]     diff;
      logic           is_hex;
      ev.kind    = EV_CONSUMED;
      ev.payload = '0;
      is_hex     = 1'b1;
      nib        = '0;
      if (c >= "0" && c <= "9") begin
         diff = c - "0";
         nib  = diff[3:0];
      end else if (c >= "a" && c <= "f") begin
         diff = c - "a" + 8'd10;
         nib  = diff[3:0];
      end else if (c >= "A" && c <= "F") begin
         diff = c - "A" + 8'd10;
         nib  = diff[3:0];
      end else begin
         is_hex = 1'b0;
      end

      if (start)
         clear_body_state();

      case (body_phase)
         PH_SIZE: begin
            if (is_hex) begin
               // one more digit must still fit in the size counter
               if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                  ev.kind = reject_body();
               end else begin
                  chunk_left      = {chunk_left[SIZE_BITS-5:0], nib};
                  size_digit_seen = 1'b1;
               end
            end else if (c == CHAR_SEMI) begin
               if (!size_digit_seen) ev.kind = reject_body();
               else body_phase = PH_EXT;
            end else if (c == CHAR_CR) begin
               body_phase = PH_SIZE_CR;
            end else begin
               ev.kind = reject_body();
            end
         end
         PH_SIZE_CR: begin
            ev.kind = (c == CHAR_LF) ? close_size_line() : reject_body();
         end
         PH_EXT: begin
            if (c == CHAR_CR) body_phase = PH_EXT_CR;
         end
         PH_EXT_CR: begin
            if (c == CHAR_LF) ev.kind = close_size_line();
            else if (c != CHAR_CR) body_phase = PH_EXT;
         end
         PH_DATA: begin
            ev.kind    = EV_DATA;
            ev.payload = c;
            if (body_total >= body_limit) body_over = 1'b1;
            if (body_total != '1) body_total = body_total + 32'd1;
            chunk_left = chunk_left - 1'b1;
            if (chunk_left == '0) body_phase = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (c == CHAR_CR) body_phase = PH_DATA_LF;
            else ev.kind = reject_body();
         end
         PH_DATA_LF: begin
            if (c == CHAR_LF) begin
               body_phase      = PH_SIZE;
               chunk_left      = '0;
               size_digit_seen = 1'b0;
            end else begin
               ev.kind = reject_body();
            end
         end
         PH_LAST_CR: begin
            if (c == CHAR_CR) body_phase = PH_LAST_LF;
            else ev.kind = reject_body();
         end
         PH_LAST_LF: begin
            if (c == CHAR_LF) begin
               body_phase = PH_DONE;
               ev.kind    = body_over ? EV_TOO_LARGE : EV_COMPLETE;
            end else begin
               ev.kind = reject_body();
            end
         end
         default: begin
            body_phase = PH_DONE;
         end
      endcase
      return ev;
   endfunction

   // ---------------------------------------------------------------------
   // Request monitor: predict on every accepted request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         // bytes after the end of a body are only ignored; keep them out of the count
         if (req_tuser || body_phase != PH_DONE)
            parsed_count++;
         expected_events.insert(expected_events.size(),
                                decode_body_byte(req_tuser, req_tdata));
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: compare each accepted response with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      body_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("tb: response with nothing predicted: kind %0d data %02h",
                        rsp_tdata[2:0], rsp_tdata[10:3]);
         end else begin
            want = expected_events.pop_front();
            if (rsp_tdata[2:0] !== want.kind || rsp_tdata[10:3] !== want.payload ||
                rsp_tdata[15:11] !== 5'd0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("tb: mismatch: expected kind %0d data %02h, got kind %0d data %02h pad %02h",
                           want.kind, want.payload, rsp_tdata[2:0], rsp_tdata[10:3],
                           rsp_tdata[15:11]);
            end
         end
      end
   end

   // receiver side: stall at random at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Shared stimulus tasks
   // ---------------------------------------------------------------------

   // Present one request and hold it until accepted. Called from clock-synchronous stimulus code.
   task automatic send_req(input logic start, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a string; the first byte optionally starts a new message.
   task automatic send_text(input string s, input logic start_first);
      for (int i = 0; i < s.len(); i++)
         send_req(start_first && i == 0, s[i]);
   endtask

   // Drop valid and wait until every predicted response has drained.
   // Wait for the clock first so the last accepted request is already predicted.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_body_limit(input logic [31:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      body_limit = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return 8'("0") + n;
      return (upper ? 8'("A") : 8'("a")) + (n - 4'd10);
   endfunction

   // Append one byte to the message under construction.
   function automatic void add_msg_byte(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endfunction

   // Append a size line: optional leading zeros, mixed case, optional extension.
   task automatic add_size_line(input logic [31:0] size);
      int top;
      top = 0;
      for (int k = 7; k >= 0; k--)
         if (top == 0 && size[4*k +: 4] != 4'd0) top = k;
      repeat ($urandom_range(0, 2)) add_msg_byte("0");
      for (int k = top; k >= 0; k--)
         add_msg_byte(hex_char(size[4*k +: 4], 1'($urandom_range(1))));
      if ($urandom_range(3) == 0) begin
         add_msg_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 4)) add_msg_byte(8'($urandom_range(255)));
      end
      add_msg_byte(CHAR_CR);
      add_msg_byte(CHAR_LF);
   endtask

   // Build one message: mostly well formed with random content, some broken or noise.
   task automatic build_message();
      int          size;
      int          pos;
      logic [7:0]  junk;
      msg_bytes.delete();
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(1, 6)) add_msg_byte(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(0, 3)) begin
         size = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         add_size_line(size);
         repeat (size) add_msg_byte(8'($urandom_range(255)));
         add_msg_byte(CHAR_CR);
         add_msg_byte(CHAR_LF);
      end
      add_size_line(0);
      add_msg_byte(CHAR_CR);
      add_msg_byte(CHAR_LF);
      // break about one message in five: overwrite, drop or insert a byte
      if ($urandom_range(4) == 0) begin
         pos  = $urandom_range(msg_bytes.size() - 1);
         junk = 8'($urandom_range(255));
         case ($urandom_range(2))
            0:       msg_bytes[pos] = junk;
            1:       msg_bytes.delete(pos);
            default: msg_bytes.insert(pos, junk);
         endcase
      end
      // stray bytes after the end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3)) add_msg_byte(8'($urandom_range(255)));
   endtask

   task automatic send_message();
      build_message();
      foreach (msg_bytes[i])
         send_req(i == 0 || $urandom_range(199) == 0, msg_bytes[i]);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Good body with extension (lone CR skipped), extreme data bytes, then ignored tail.
   task automatic test_well_formed_body();
      send_text("2;x\015\015\012", 1'b1);
      send_req(1'b0, 8'hFF);
      send_req(1'b0, 8'h00);
      send_text("\015\0120\015\012\015\012Z", 1'b0);
   endtask

   // Non-hex in size, empty size both ways, lone CR in size, overflow,
   // missing CR LF after data, and a trailer after the zero size.
   task automatic test_malformed_bodies();
      send_text("G", 1'b1);
      send_text(";", 1'b1);
      send_text("\015\012", 1'b1);
      send_text("1\015x", 1'b1);
      send_text("100000000", 1'b1);
      send_text("1\015\0125Q", 1'b1);
      send_text("0\015\012X", 1'b1);
   endtask

   // Limit extremes: zero rejects any data, one passes a single byte, all-ones passes all.
   task automatic test_body_limit();
      set_body_limit(32'd0);
      send_text("1\015\012A\015\0120\015\012\015\012", 1'b1);
      set_body_limit(32'd1);
      send_text("1\015\012A\015\0120\015\012\015\012", 1'b1);
      send_text("2\015\012AB\015\0120\015\012\015\012", 1'b1);
      set_body_limit(32'hFFFF_FFFF);
      send_text("2\015\012AB\015\0120\015\012\015\012", 1'b1);
   endtask

   // Random messages at the given pacing, across two limit settings.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
      int goal;
      logic [31:0] lim;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int blk = 0; blk < 2; blk++) begin
         case ($urandom_range(3))
            0:       lim = 32'd0;
            1:       lim = $urandom_range(0, 40);
            2:       lim = MAX_BODY_RESET;
            default: lim = 32'hFFFF_FFFF;
         endcase
         set_body_limit(lim);
         goal = parsed_count + items / 2;
         while (parsed_count < goal) send_message();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_well_formed_body();
      test_malformed_bodies();
      test_body_limit();
      test_random_traffic(20, 47, 500);
      test_random_traffic(47, 20, 500);
      test_random_traffic(0, 0, 500);

      // drain, then allow for the registered response
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
